// ----- src/polyline_normal_index_builder_core_defines.svh -----
// Assertion macros used by the direction unit of the polyline normal index builder.
`ifndef POLYLINE_NORMAL_INDEX_BUILDER_CORE_DEFINES_SVH
`define POLYLINE_NORMAL_INDEX_BUILDER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is active.
`define NIB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define NIB_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/nib_pkg.sv -----
// Package with widths, constants and shared types of the polyline normal index builder.
package nib_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int BUNDLE_BITS_DEF = 16;

    localparam int BUNDLE_W   = 16;
    localparam int INDEX_W    = 32;
    localparam int DIR_W      = 16;
    localparam int NORM_BITS  = 24;
    localparam int ACC_W      = 2 * NORM_BITS + 2;
    localparam int SQRT_STEPS = NORM_BITS + 1;
    localparam int Q_BITS     = 15;
    localparam int CNT_W      = $clog2(SQRT_STEPS);
    localparam int ONE_Q14    = 16384;

    typedef struct packed {
        logic start;
    } t_dir_ctl;

    typedef struct packed {
        logic done;
        logic degenerate;
    } t_dir_sts;

    typedef struct packed {
        logic [INDEX_W-1:0]      vertex_index;
        logic signed [DIR_W-1:0] dir_x;
        logic signed [DIR_W-1:0] dir_y;
        logic signed [DIR_W-1:0] dir_z;
        logic [BUNDLE_W-1:0]     colour;
        logic                    restart_after;
        logic                    degenerate;
        logic                    last;
    } t_result;

endpackage

// ----- src/nib_if.sv -----
// Valid/ready channel interfaces for point input and vertex output.
interface nib_in_if import nib_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
    logic                   valid;
    logic                   ready;
    logic [COORD_WIDTH-1:0] point_x;
    logic [COORD_WIDTH-1:0] point_y;
    logic [COORD_WIDTH-1:0] point_z;
    logic [BUNDLE_W-1:0]    bundle_id;
    logic                   fiber_end;

    modport source (output valid, point_x, point_y, point_z, bundle_id, fiber_end,
                    input ready);
    modport sink (input valid, point_x, point_y, point_z, bundle_id, fiber_end,
                  output ready);
endinterface

interface nib_out_if import nib_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic [INDEX_W-1:0]      vertex_index;
    logic signed [DIR_W-1:0] dir_x;
    logic signed [DIR_W-1:0] dir_y;
    logic signed [DIR_W-1:0] dir_z;
    logic [BUNDLE_W-1:0]     colour;
    logic                    restart_after;
    logic                    degenerate;
    logic                    last;

    modport source (output valid, vertex_index, dir_x, dir_y, dir_z, colour,
                    restart_after, degenerate, last, input ready);
    modport sink (input valid, vertex_index, dir_x, dir_y, dir_z, colour,
                  restart_after, degenerate, last, output ready);
endinterface

// ----- src/nib_dir_unit.sv -----
// Iterative unit that turns a segment into a Q1.14 unit direction on one shared subtractor.
`include "polyline_normal_index_builder_core_defines.svh"

module nib_dir_unit import nib_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_dir_ctl                i_ctl,
    input  logic [COORD_WIDTH-1:0]  i_px,
    input  logic [COORD_WIDTH-1:0]  i_py,
    input  logic [COORD_WIDTH-1:0]  i_pz,
    input  logic [COORD_WIDTH-1:0]  i_hx,
    input  logic [COORD_WIDTH-1:0]  i_hy,
    input  logic [COORD_WIDTH-1:0]  i_hz,
    output t_dir_sts                o_sts,
    output logic signed [DIR_W-1:0] o_dir_x,
    output logic signed [DIR_W-1:0] o_dir_y,
    output logic signed [DIR_W-1:0] o_dir_z
);

    localparam int DW = COORD_WIDTH + 1;
    localparam int MW = (DW > NORM_BITS + 1) ? DW : NORM_BITS + 1;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_NORM = 7'b0000010,
        S_MUL  = 7'b0000100,
        S_SQRT = 7'b0001000,
        S_DLD  = 7'b0010000,
        S_DIV  = 7'b0100000,
        S_DST  = 7'b1000000
    } t_dir_state;

    t_dir_state r_state;
    logic [CNT_W-1:0] r_cnt;
    logic [1:0] r_k;
    logic [MW-1:0] r_mag_x, r_mag_y, r_mag_z;
    logic r_sgn_x, r_sgn_y, r_sgn_z;
    logic [2*NORM_BITS-1:0] r_prod;
    logic [ACC_W-1:0] r_acc, r_rem, r_root, r_bit, r_dsh;
    logic [Q_BITS-1:0] r_q;
    logic signed [DIR_W-1:0] r_dir_x, r_dir_y, r_dir_z;
    logic r_deg;
    logic r_done;

    logic [DW-1:0] w_dx, w_dy, w_dz;
    logic [DW-1:0] w_ax, w_ay, w_az;
    logic w_zero, w_hi, w_lo;
    logic [1:0] w_sel;
    logic [NORM_BITS-1:0] w_pick;
    logic w_pick_sgn;
    logic [ACC_W-1:0] w_opa, w_opb;
    logic [ACC_W:0] w_diff;
    logic w_ge;
    logic [DIR_W-1:0] w_qs, w_dir;

    assign w_dx = {i_px[COORD_WIDTH-1], i_px} - {i_hx[COORD_WIDTH-1], i_hx};
    assign w_dy = {i_py[COORD_WIDTH-1], i_py} - {i_hy[COORD_WIDTH-1], i_hy};
    assign w_dz = {i_pz[COORD_WIDTH-1], i_pz} - {i_hz[COORD_WIDTH-1], i_hz};
    assign w_ax = w_dx[DW-1] ? (~w_dx + 1'b1) : w_dx;
    assign w_ay = w_dy[DW-1] ? (~w_dy + 1'b1) : w_dy;
    assign w_az = w_dz[DW-1] ? (~w_dz + 1'b1) : w_dz;
    assign w_zero = (w_dx == '0) && (w_dy == '0) && (w_dz == '0);

    assign w_hi = |{r_mag_x[MW-1:NORM_BITS], r_mag_y[MW-1:NORM_BITS],
                    r_mag_z[MW-1:NORM_BITS]};
    assign w_lo = ~|{r_mag_x[MW-1:NORM_BITS-1], r_mag_y[MW-1:NORM_BITS-1],
                     r_mag_z[MW-1:NORM_BITS-1]};

    assign w_sel = (r_state == S_MUL) ? r_cnt[1:0] : r_k;

    always_comb begin
        case (w_sel)
            2'd0: begin
                w_pick     = r_mag_x[NORM_BITS-1:0];
                w_pick_sgn = r_sgn_x;
            end
            2'd1: begin
                w_pick     = r_mag_y[NORM_BITS-1:0];
                w_pick_sgn = r_sgn_y;
            end
            default: begin
                w_pick     = r_mag_z[NORM_BITS-1:0];
                w_pick_sgn = r_sgn_z;
            end
        endcase
    end

    // The one subtract-and-compare shared by the square root and the divisions.
    always_comb begin
        w_opa = '0;
        w_opb = '0;
        if (r_state == S_SQRT) begin
            w_opa = r_rem;
            w_opb = r_root + r_bit;
        end else if (r_state == S_DIV) begin
            w_opa = r_rem;
            w_opb = r_dsh;
        end
    end

    assign w_diff = {1'b0, w_opa} - {1'b0, w_opb};
    assign w_ge   = ~w_diff[ACC_W];

    assign w_qs  = {1'b0, r_q};
    assign w_dir = w_pick_sgn ? (~w_qs + 1'b1) : w_qs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
            r_k     <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_ctl.start) begin
                        if (w_zero) begin
                            r_dir_x <= '0;
                            r_dir_y <= '0;
                            r_dir_z <= '0;
                            r_deg   <= 1'b1;
                            r_done  <= 1'b1;
                        end else begin
                            r_mag_x <= MW'(w_ax);
                            r_mag_y <= MW'(w_ay);
                            r_mag_z <= MW'(w_az);
                            r_sgn_x <= w_dx[DW-1];
                            r_sgn_y <= w_dy[DW-1];
                            r_sgn_z <= w_dz[DW-1];
                            r_state <= S_NORM;
                        end
                    end
                end
                S_NORM: begin
                    if (w_hi) begin
                        r_mag_x <= r_mag_x >> 1;
                        r_mag_y <= r_mag_y >> 1;
                        r_mag_z <= r_mag_z >> 1;
                    end else if (w_lo) begin
                        r_mag_x <= r_mag_x << 1;
                        r_mag_y <= r_mag_y << 1;
                        r_mag_z <= r_mag_z << 1;
                    end else begin
                        r_cnt   <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod <= w_pick * w_pick;
                    if (r_cnt == '0) begin
                        r_acc <= '0;
                    end else begin
                        r_acc <= r_acc + ACC_W'(r_prod);
                    end
                    if (r_cnt == CNT_W'(3)) begin
                        r_rem   <= r_acc + ACC_W'(r_prod);
                        r_root  <= '0;
                        r_bit   <= ACC_W'(1) << (2 * (SQRT_STEPS - 1));
                        r_cnt   <= '0;
                        r_state <= S_SQRT;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_SQRT: begin
                    if (w_ge) begin
                        r_rem  <= w_diff[ACC_W-1:0];
                        r_root <= (r_root >> 1) + r_bit;
                    end else begin
                        r_root <= r_root >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_cnt == CNT_W'(SQRT_STEPS - 1)) begin
                        r_k     <= '0;
                        r_state <= S_DLD;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_DLD: begin
                    r_rem   <= (ACC_W'(w_pick) << (Q_BITS - 1)) + (r_root >> 1);
                    r_dsh   <= r_root << (Q_BITS - 1);
                    r_q     <= '0;
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_ge) begin
                        r_rem <= w_diff[ACC_W-1:0];
                    end
                    r_q   <= {r_q[Q_BITS-2:0], w_ge};
                    r_dsh <= r_dsh >> 1;
                    if (r_cnt == CNT_W'(Q_BITS - 1)) begin
                        r_state <= S_DST;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_DST: begin
                    case (r_k)
                        2'd0:    r_dir_x <= w_dir;
                        2'd1:    r_dir_y <= w_dir;
                        default: r_dir_z <= w_dir;
                    endcase
                    if (r_k == 2'd2) begin
                        r_deg   <= 1'b0;
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_DLD;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_sts.done       = r_done;
    assign o_sts.degenerate = r_deg;
    assign o_dir_x          = r_dir_x;
    assign o_dir_y          = r_dir_y;
    assign o_dir_z          = r_dir_z;

    `NIB_ASSERT_IMP(a_start_idle, i_clk, i_rst_n, i_ctl.start, r_state == S_IDLE, "start while busy")
    `NIB_ASSERT_NXT(a_done_pulse, i_clk, i_rst_n, r_done, !r_done && (r_state == S_IDLE), "done held")
    `NIB_ASSERT_IMP(a_deg_zero, i_clk, i_rst_n, r_done && r_deg, (r_dir_x == '0) && (r_dir_y == '0) && (r_dir_z == '0), "degenerate direction not zero")
    `NIB_ASSERT_IMP(a_dir_range, i_clk, i_rst_n, r_done && !r_deg, (r_dir_x <= ONE_Q14) && (r_dir_x >= -ONE_Q14) && (r_dir_y <= ONE_Q14) && (r_dir_y >= -ONE_Q14) && (r_dir_z <= ONE_Q14) && (r_dir_z >= -ONE_Q14), "direction out of range")

endmodule

// ----- src/nib_out_fifo.sv -----
// Two-entry result queue that drives the vertex output channel.
module nib_out_fifo import nib_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_result   i_data,
    output logic      o_full,
    nib_out_if.source o_out
);

    t_result    r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_pop;
    t_result    w_head;

    assign w_pop  = o_out.valid && o_out.ready;
    assign o_full = (r_cnt == 2'd2);
    assign w_head = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, w_pop};
        end
    end

    assign o_out.valid         = (r_cnt != 2'd0);
    assign o_out.vertex_index  = w_head.vertex_index;
    assign o_out.dir_x         = w_head.dir_x;
    assign o_out.dir_y         = w_head.dir_y;
    assign o_out.dir_z         = w_head.dir_z;
    assign o_out.colour        = w_head.colour;
    assign o_out.restart_after = w_head.restart_after;
    assign o_out.degenerate    = w_head.degenerate;
    assign o_out.last          = w_head.last;

endmodule

// ----- src/polyline_normal_index_builder_core.sv -----
// Top level of the polyline normal index builder: fiber state, sequencing and output queue.
//
// Points of line strips arrive on i_in, one per transfer, with their bundle number and a
// mark on the last point of each fiber. Vertices leave on o_out once the following point is
// known: the running index, the Q1.14 unit direction toward the next point, the bundle as
// colour, a restart mark on each fiber's last vertex and a degenerate mark for zero-length
// segments. One input causes zero, one or two output transfers; last marks the final one.
// A point that has a held predecessor runs through the direction unit: a one-bit-per-cycle
// normalizing shift, a multiply-accumulate of the squared components, a 25-step square root
// and three 15-step divisions. A zero-length segment skips the iterations, and a point
// without a held predecessor does not use the direction unit. i_in.ready is high only while
// no point is in work. Results go into a two-entry queue, so the next point is taken while
// earlier vertices still wait; a stalled receiver holds back the block only once the queue
// is full. Reset clears the held point, sets the last direction to one in every axis and
// restarts the vertex index at zero.
module polyline_normal_index_builder_core import nib_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int BUNDLE_BITS = BUNDLE_BITS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    nib_in_if.sink  i_in,
    nib_out_if.source o_out
);

    localparam int HB_W = (BUNDLE_BITS < BUNDLE_W) ? BUNDLE_BITS : BUNDLE_W;

    typedef enum logic [3:0] {
        T_IDLE  = 4'b0001,
        T_START = 4'b0010,
        T_WAIT  = 4'b0100,
        T_PUSH  = 4'b1000
    } t_top_state;

    t_top_state r_state;
    logic [COORD_WIDTH-1:0] r_px, r_py, r_pz;
    logic [COORD_WIDTH-1:0] r_hx, r_hy, r_hz;
    logic [HB_W-1:0] r_pb, r_hb;
    logic r_end;
    logic r_hvalid;
    logic signed [DIR_W-1:0] r_ldir_x, r_ldir_y, r_ldir_z;
    logic r_ldeg;
    logic [INDEX_W-1:0] r_index;
    logic r_need_a, r_need_b;

    t_dir_ctl w_ctl;
    t_dir_sts w_sts;
    logic signed [DIR_W-1:0] w_dir_x, w_dir_y, w_dir_z;
    logic w_accept;
    logic w_full;
    logic w_push;
    t_result w_res;

    assign i_in.ready = (r_state == T_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_ctl.start = (r_state == T_START);
    assign w_push     = (r_state == T_PUSH) && (r_need_a || r_need_b) && !w_full;

    always_comb begin
        w_res.vertex_index  = r_index;
        w_res.dir_x         = r_ldir_x;
        w_res.dir_y         = r_ldir_y;
        w_res.dir_z         = r_ldir_z;
        w_res.degenerate    = r_ldeg;
        if (r_need_a) begin
            w_res.colour        = BUNDLE_W'(r_hb);
            w_res.restart_after = 1'b0;
            w_res.last          = !r_end;
        end else begin
            w_res.colour        = BUNDLE_W'(r_pb);
            w_res.restart_after = 1'b1;
            w_res.last          = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_px <= i_in.point_x;
            r_py <= i_in.point_y;
            r_pz <= i_in.point_z;
            r_pb <= i_in.bundle_id[HB_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= T_IDLE;
            r_hvalid <= 1'b0;
            r_ldir_x <= DIR_W'(ONE_Q14);
            r_ldir_y <= DIR_W'(ONE_Q14);
            r_ldir_z <= DIR_W'(ONE_Q14);
            r_ldeg   <= 1'b0;
            r_index  <= '0;
            r_need_a <= 1'b0;
            r_need_b <= 1'b0;
            r_end    <= 1'b0;
        end else begin
            unique case (r_state)
                T_IDLE: begin
                    if (w_accept) begin
                        r_end    <= i_in.fiber_end;
                        r_need_a <= r_hvalid;
                        r_need_b <= i_in.fiber_end;
                        r_state  <= r_hvalid ? T_START : T_PUSH;
                    end
                end
                T_START: begin
                    r_state <= T_WAIT;
                end
                T_WAIT: begin
                    if (w_sts.done) begin
                        r_ldir_x <= w_dir_x;
                        r_ldir_y <= w_dir_y;
                        r_ldir_z <= w_dir_z;
                        r_ldeg   <= w_sts.degenerate;
                        r_state  <= T_PUSH;
                    end
                end
                T_PUSH: begin
                    if (!r_need_a && !r_need_b) begin
                        if (r_end) begin
                            r_hvalid <= 1'b0;
                        end else begin
                            r_hx     <= r_px;
                            r_hy     <= r_py;
                            r_hz     <= r_pz;
                            r_hb     <= r_pb;
                            r_hvalid <= 1'b1;
                        end
                        r_state <= T_IDLE;
                    end else if (w_push) begin
                        r_index <= r_index + 1'b1;
                        if (r_need_a) begin
                            r_need_a <= 1'b0;
                        end else begin
                            r_need_b <= 1'b0;
                        end
                    end
                end
                default: r_state <= T_IDLE;
            endcase
        end
    end

    nib_dir_unit #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_dir (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (w_ctl),
        .i_px   (r_px),
        .i_py   (r_py),
        .i_pz   (r_pz),
        .i_hx   (r_hx),
        .i_hy   (r_hy),
        .i_hz   (r_hz),
        .o_sts  (w_sts),
        .o_dir_x(w_dir_x),
        .o_dir_y(w_dir_y),
        .o_dir_z(w_dir_z)
    );

    nib_out_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_data (w_res),
        .o_full (w_full),
        .o_out  (o_out)
    );

endmodule
